// ----- rtl/tfp_pkg.sv -----
package tfp_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int WORD_WIDTH  = 32;
   localparam int CHECK_WIDTH = 16;
   localparam int NUM_WORDS   = 7;
   localparam int POS_WIDTH   = 6;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // Byte positions within a frame
   localparam logic [POS_WIDTH-1:0] POS_START      = 6'd0;
   localparam logic [POS_WIDTH-1:0] POS_LENGTH     = 6'd1;
   localparam logic [POS_WIDTH-1:0] POS_SEQ        = 6'd2;
   localparam logic [POS_WIDTH-1:0] POS_SYSID      = 6'd3;
   localparam logic [POS_WIDTH-1:0] POS_COMPID     = 6'd4;
   localparam logic [POS_WIDTH-1:0] POS_MSGID      = 6'd5;
   localparam logic [POS_WIDTH-1:0] POS_PAYLOAD    = 6'd6;
   localparam logic [POS_WIDTH-1:0] POS_CHECK_LOW  = 6'd34;
   localparam logic [POS_WIDTH-1:0] POS_CHECK_HIGH = 6'd35;
   localparam logic [POS_WIDTH-1:0] FRAME_BYTES    = 6'd36;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_BYTE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXP_LENGTH   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXP_MSG_ID   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXP_CHECK    = 2'd3;

   localparam logic [BYTE_WIDTH-1:0]  START_BYTE_RESET  = 8'd254;
   localparam logic [BYTE_WIDTH-1:0]  EXP_LENGTH_RESET  = 8'd28;
   localparam logic [BYTE_WIDTH-1:0]  EXP_MSG_ID_RESET  = 8'd32;
   localparam logic [CHECK_WIDTH-1:0] EXP_CHECK_RESET   = 16'd0;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_START  = 3'd1,
      STATUS_BAD_LENGTH = 3'd2,
      STATUS_BAD_MSG_ID = 3'd3,
      STATUS_BAD_CHECK  = 3'd4
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [BYTE_WIDTH-1:0]  sequence_res;
      logic [BYTE_WIDTH-1:0]  system_id;
      logic [BYTE_WIDTH-1:0]  component_id;
      logic [WORD_WIDTH-1:0]  timestamp;
      logic [WORD_WIDTH-1:0]  pos_x;
      logic [WORD_WIDTH-1:0]  pos_y;
      logic [WORD_WIDTH-1:0]  pos_z;
      logic [WORD_WIDTH-1:0]  vel_x;
      logic [WORD_WIDTH-1:0]  vel_y;
      logic [WORD_WIDTH-1:0]  vel_z;
      logic [CHECK_WIDTH-1:0] received_check;
   } rsp_payload_type;

endpackage

// ----- rtl/tfp_req_if.sv -----
interface tfp_req_if;
   logic                            valid;
   logic                            ready;
   logic [tfp_pkg::BYTE_WIDTH-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/tfp_rsp_if.sv -----
interface tfp_rsp_if;
   logic                      valid;
   logic                      ready;
   tfp_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/telemetry_frame_parser_top.sv -----
// Telemetry frame parser: takes one received serial byte per req_ch transaction
// and deframes a fixed 36-byte frame (start, length, sequence, system id,
// component id, message id, 28 payload bytes as seven little-endian 32-bit
// words, little-endian check word). A wrong start, length or message id byte
// produces an error transaction on rsp_ch at once, with all other fields zero,
// and the hunt for a start byte resumes with the next byte. The last check
// byte produces one transaction: ok if the check word equals the expected_check
// register, bad check otherwise; no CRC is computed. Throughput is one byte per
// clock unless a result stalls behind a full output, set by the single frame
// position counter that steps once per byte. A byte waits in the input register
// until it advances; its result, if any, is then loaded into the output
// register, from which it is offered on rsp_ch. While a result waits on
// rsp_ch, bytes that produce no result keep flowing; only a byte that itself
// produces a result stalls behind a full output, and req_ch then holds off.
// Configuration registers (csr_index): 0 start byte (reset 254), 1 expected
// length (reset 28), 2 expected message id (reset 32), 3 expected check word
// (reset 0); write them only while the parser is idle.
module telemetry_frame_parser_top (
   input  logic                                  clock,
   input  logic                                  reset,
   tfp_req_if.sink                               req_ch,
   tfp_rsp_if.source                             rsp_ch,
   input  logic                                  csr_write_en,
   input  logic [tfp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tfp_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import tfp_pkg::*;

   // configuration registers
   logic [BYTE_WIDTH-1:0]  start_byte_ff;
   logic [BYTE_WIDTH-1:0]  exp_length_ff;
   logic [BYTE_WIDTH-1:0]  exp_msg_id_ff;
   logic [CHECK_WIDTH-1:0] exp_check_ff;

   // input register
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [BYTE_WIDTH-1:0]  in_byte_ff;

   // frame state
   logic [POS_WIDTH-1:0]   pos_ff;
   logic [POS_WIDTH-1:0]   pos_in;
   logic [BYTE_WIDTH-1:0]  seq_ff;
   logic [BYTE_WIDTH-1:0]  sysid_ff;
   logic [BYTE_WIDTH-1:0]  compid_ff;
   logic [BYTE_WIDTH-1:0]  check_low_ff;
   logic [WORD_WIDTH-1:0]  payload_ff [NUM_WORDS];

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_payload_type        rsp_payload_ff;
   rsp_payload_type        result;

   logic                   accept;
   logic                   advance;
   logic                   emit;
   logic                   out_free;
   logic                   payload_we;
   logic [POS_WIDTH-1:0]   pos_eff;
   logic [POS_WIDTH-1:0]   pay_off;
   logic [2:0]             pay_word;
   logic [1:0]             pay_lane;
   logic [CHECK_WIDTH-1:0] check_word;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && (out_free || !emit);
   assign req_ch.ready = !reset && (!in_valid_ff || advance);
   assign accept       = req_ch.valid && req_ch.ready;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign pay_off    = pos_eff - POS_PAYLOAD;
   assign pay_word   = pay_off[4:2];
   assign pay_lane   = pay_off[1:0];
   assign check_word = {in_byte_ff, check_low_ff};

   // decode the byte in the input register against the frame position
   always_comb begin
      pos_eff    = (pos_ff >= FRAME_BYTES) ? POS_START : pos_ff;
      pos_in     = pos_eff + 6'd1;
      emit       = 1'b0;
      payload_we = 1'b0;
      result     = '0;
      case (pos_eff)
         POS_START: begin
            if (in_byte_ff != start_byte_ff) begin
               emit          = 1'b1;
               result.status = STATUS_BAD_START;
               pos_in        = POS_START;
            end
         end
         POS_LENGTH: begin
            if (in_byte_ff != exp_length_ff) begin
               emit          = 1'b1;
               result.status = STATUS_BAD_LENGTH;
               pos_in        = POS_START;
            end
         end
         POS_SEQ, POS_SYSID, POS_COMPID, POS_CHECK_LOW: begin
            // capture happens in the state block
         end
         POS_MSGID: begin
            if (in_byte_ff != exp_msg_id_ff) begin
               emit          = 1'b1;
               result.status = STATUS_BAD_MSG_ID;
               pos_in        = POS_START;
            end
         end
         POS_CHECK_HIGH: begin
            // frame complete
            emit                  = 1'b1;
            result.status         = (check_word == exp_check_ff) ? STATUS_OK
                                                                 : STATUS_BAD_CHECK;
            result.sequence_res   = seq_ff;
            result.system_id      = sysid_ff;
            result.component_id   = compid_ff;
            result.timestamp      = payload_ff[0];
            result.pos_x          = payload_ff[1];
            result.pos_y          = payload_ff[2];
            result.pos_z          = payload_ff[3];
            result.vel_x          = payload_ff[4];
            result.vel_y          = payload_ff[5];
            result.vel_z          = payload_ff[6];
            result.received_check = check_word;
            pos_in                = POS_START;
         end
         default: begin
            // payload bytes
            payload_we = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = (advance && emit) ? 1'b1
                       : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= POS_START;
         seq_ff        <= '0;
         sysid_ff      <= '0;
         compid_ff     <= '0;
         check_low_ff  <= '0;
         start_byte_ff <= START_BYTE_RESET;
         exp_length_ff <= EXP_LENGTH_RESET;
         exp_msg_id_ff <= EXP_MSG_ID_RESET;
         exp_check_ff  <= EXP_CHECK_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pos_ff <= pos_in;
            if (pos_eff == POS_SEQ)       seq_ff       <= in_byte_ff;
            if (pos_eff == POS_SYSID)     sysid_ff     <= in_byte_ff;
            if (pos_eff == POS_COMPID)    compid_ff    <= in_byte_ff;
            if (pos_eff == POS_CHECK_LOW) check_low_ff <= in_byte_ff;
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_START_BYTE: start_byte_ff <= csr_write_data[BYTE_WIDTH-1:0];
               CSR_EXP_LENGTH: exp_length_ff <= csr_write_data[BYTE_WIDTH-1:0];
               CSR_EXP_MSG_ID: exp_msg_id_ff <= csr_write_data[BYTE_WIDTH-1:0];
               CSR_EXP_CHECK:  exp_check_ff  <= csr_write_data[CHECK_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers: hold the byte, load the word lane, load the result
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      if (advance && payload_we) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            for (int l = 0; l < 4; l++) begin
               if (pay_word == 3'(w) && pay_lane == 2'(l)) begin
                  payload_ff[w][l*BYTE_WIDTH +: BYTE_WIDTH] <= in_byte_ff;
               end
            end
         end
      end
      if (advance && emit) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   // error transactions carry nothing but their status
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_payload_ff.status == STATUS_BAD_START
         || rsp_payload_ff.status == STATUS_BAD_LENGTH
         || rsp_payload_ff.status == STATUS_BAD_MSG_ID)
      |-> rsp_payload_ff.sequence_res == '0 && rsp_payload_ff.timestamp == '0
         && rsp_payload_ff.received_check == '0)
      else $error("error transaction carries nonzero fields");

   // any emitted result restarts the hunt for a start byte
   a_restart: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> pos_ff == POS_START)
      else $error("position not restarted after result");

   // a byte waiting in the input register is never overwritten
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("pending input byte lost");

   // the position counter stays inside the frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < FRAME_BYTES)
      else $error("frame position out of range");

endmodule
